FILE: rtl/oul_pkg.sv
// Shared types and codes of the ordered unique value list.
// Used by oul_cell and ordered_unique_value_list_unit.
package oul_pkg;

  localparam int KIND_W = 4;
  localparam int POS_W  = 6;
  localparam int STAT_W = 3;
  localparam int DATA_W = 32;
  localparam int WHERE_W = 5;
  localparam int SIZE_W = 6;
  localparam int CTL_W  = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD        = 4'd0,
    KIND_ADD_ABSENT = 4'd1,
    KIND_INSERT     = 4'd2,
    KIND_MOVE       = 4'd3,
    KIND_REMOVE     = 4'd4,
    KIND_REMOVE_PRES = 4'd5,
    KIND_CLEAR      = 4'd6,
    KIND_FIND       = 4'd7,
    KIND_READ_AT    = 4'd8,
    KIND_READ_RANGE = 4'd9
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_DUP    = 3'd1,
    STAT_ABSENT = 3'd2,
    STAT_BADIDX = 3'd3,
    STAT_FULL   = 3'd4,
    STAT_EMPTY  = 3'd5
  } stat_t;

  typedef struct packed {
    logic             ld;
    logic [CTL_W-1:0] ld_idx;
    logic             shl;
    logic             shr;
    logic [CTL_W-1:0] lo;
    logic [CTL_W-1:0] hi;
  } cell_ctl_t;

endpackage

FILE: rtl/ordered_unique_value_list_unit.sv
// Top level of the ordered unique value list: cell row, control and result register.
// Depends on oul_pkg and oul_cell.
//
// The list lives in a row of DEPTH cells, one value per cell. An item is taken in S_IDLE
// and executed in S_EXEC: all cells compare against the value at once, and an
// insert, remove or move shifts the affected cells by one place in that same cycle. A range
// read streams its further results from S_RANGE, one per cycle while the output register is
// free. The next item is taken while a result still waits in the output register; execution
// holds until that register is free. No clearing pass follows reset.
module ordered_unique_value_list_unit import oul_pkg::*; #(
  parameter int DEPTH       = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [DATA_W-1:0]  in_value,
  input  logic [POS_W-1:0]          in_position,
  input  logic [POS_W-1:0]          in_target,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [DATA_W-1:0]  out_data,
  output logic [WHERE_W-1:0]        out_where,
  output logic                      out_found,
  output logic [SIZE_W-1:0]         out_size_now,
  output logic                      out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_RANGE = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          fill_r, fill_nxt;
  logic [KIND_W-1:0]      op_kind_r;
  logic [VALUE_WIDTH-1:0] op_val_r;
  logic [POS_W-1:0]       op_pos_r;
  logic [POS_W-1:0]       op_tgt_r;
  logic [EW-1:0]          cur_r, cur_nxt;
  logic [EW-1:0]          stop_r, stop_nxt;

  logic                   out_valid_r;
  logic [STAT_W-1:0]      out_status_r;
  logic [DATA_W-1:0]      out_data_r;
  logic [WHERE_W-1:0]     out_where_r;
  logic                   out_found_r;
  logic [SIZE_W-1:0]      out_size_r;
  logic                   out_last_r;

  logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]       cell_hit;
  cell_ctl_t              ctl;

  logic                   slot_free;
  logic                   emit;
  logic                   use_rd;
  stat_t                  stat;
  logic                   found_v;
  logic                   last_v;
  logic [EW-1:0]          pos_e, tgt_e, fill_e;
  logic [EW-1:0]          at_e, dst_e, stop_v, rd_idx;
  logic                   present;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   is_full;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign pos_e     = EW'(op_pos_r);
  assign tgt_e     = EW'(op_tgt_r);
  assign fill_e    = EW'(fill_r);
  assign present   = |cell_hit;
  assign is_full   = (fill_r == CW'(DEPTH));
  assign rd_idx    = (state_r == S_RANGE) ? cur_r : pos_e;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_d, right_d;
      if (g == 0) begin : g_first
        assign left_d = op_val_r;
      end else begin : g_mid_l
        assign left_d = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_d = op_val_r;
      end else begin : g_mid_r
        assign right_d = cell_data[g+1];
      end
      oul_cell #(
        .IDX         (g),
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .key        (op_val_r),
        .fill       (CTL_W'(fill_r)),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_data[g]),
        .hit        (cell_hit[g])
      );
    end
  endgenerate

  always_comb begin
    at_e    = '0;
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_hit[i]) begin
        at_e = at_e | EW'(i);
      end
      if (EW'(i) == rd_idx) begin
        rd_data = rd_data | cell_data[i];
      end
    end
  end

  always_comb begin
    ctl       = '0;
    stat      = STAT_OK;
    found_v   = 1'b0;
    last_v    = 1'b1;
    use_rd    = 1'b0;
    emit      = 1'b0;
    fill_nxt  = fill_r;
    state_nxt = state_r;
    cur_nxt   = cur_r;
    stop_nxt  = stop_r;
    dst_e     = '0;
    stop_v    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          unique case (op_kind_r)
            KIND_ADD, KIND_ADD_ABSENT: begin
              if (present) begin
                stat = (op_kind_r == KIND_ADD) ? STAT_DUP : STAT_OK;
              end else if (is_full) begin
                stat = STAT_FULL;
              end else begin
                ctl.ld     = 1'b1;
                ctl.ld_idx = CTL_W'(fill_e);
                fill_nxt   = fill_r + 1'b1;
              end
            end
            KIND_INSERT: begin
              if (present) begin
                stat = STAT_DUP;
              end else if (pos_e > fill_e) begin
                stat = STAT_BADIDX;
              end else if (is_full) begin
                stat = STAT_FULL;
              end else begin
                ctl.ld     = 1'b1;
                ctl.ld_idx = CTL_W'(pos_e);
                ctl.shl    = 1'b1;
                ctl.lo     = CTL_W'(pos_e) + 1'b1;
                ctl.hi     = CTL_W'(DEPTH - 1);
                fill_nxt   = fill_r + 1'b1;
              end
            end
            KIND_MOVE: begin
              if (!present) begin
                stat = STAT_ABSENT;
              end else if (tgt_e > fill_e) begin
                stat = STAT_BADIDX;
              end else begin
                dst_e      = (tgt_e == fill_e) ? fill_e - 1'b1 : tgt_e;
                ctl.ld     = 1'b1;
                ctl.ld_idx = CTL_W'(dst_e);
                if (dst_e < at_e) begin
                  ctl.shl = 1'b1;
                  ctl.lo  = CTL_W'(dst_e) + 1'b1;
                  ctl.hi  = CTL_W'(at_e);
                end else if (dst_e > at_e) begin
                  ctl.shr = 1'b1;
                  ctl.lo  = CTL_W'(at_e);
                  ctl.hi  = CTL_W'(dst_e) - 1'b1;
                end
              end
            end
            KIND_REMOVE, KIND_REMOVE_PRES: begin
              if (present) begin
                ctl.shr  = 1'b1;
                ctl.lo   = CTL_W'(at_e);
                ctl.hi   = CTL_W'(DEPTH - 1);
                fill_nxt = fill_r - 1'b1;
              end else begin
                stat = (op_kind_r == KIND_REMOVE) ? STAT_ABSENT : STAT_OK;
              end
            end
            KIND_CLEAR: begin
              fill_nxt = '0;
            end
            KIND_FIND: begin
              found_v = present;
              if (!present) begin
                stat = STAT_ABSENT;
              end
            end
            KIND_READ_AT: begin
              if (pos_e < fill_e) begin
                use_rd = 1'b1;
              end else begin
                stat = STAT_BADIDX;
              end
            end
            KIND_READ_RANGE: begin
              if (tgt_e < pos_e) begin
                stat = STAT_BADIDX;
              end else if (pos_e >= fill_e) begin
                stat = STAT_EMPTY;
              end else begin
                stop_v   = (tgt_e < fill_e) ? tgt_e : fill_e - 1'b1;
                use_rd   = 1'b1;
                last_v   = (pos_e == stop_v);
                cur_nxt  = pos_e + 1'b1;
                stop_nxt = stop_v;
                if (!last_v) begin
                  state_nxt = S_RANGE;
                end
              end
            end
            default: begin
              stat = STAT_OK;
            end
          endcase
        end
      end
      S_RANGE: begin
        if (slot_free) begin
          emit    = 1'b1;
          use_rd  = 1'b1;
          last_v  = (cur_r == stop_r);
          cur_nxt = cur_r + 1'b1;
          if (last_v) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    stop_r <= stop_nxt;
    if (in_valid && in_ready) begin
      op_kind_r <= in_kind;
      op_val_r  <= VALUE_WIDTH'($unsigned(in_value));
      op_pos_r  <= in_position;
      op_tgt_r  <= in_target;
    end
    if (emit) begin
      out_status_r <= stat;
      out_data_r   <= use_rd ? DATA_W'(rd_data) : '0;
      out_where_r  <= found_v ? at_e[WHERE_W-1:0] : '0;
      out_found_r  <= found_v;
      out_size_r   <= SIZE_W'(fill_nxt);
      out_last_r   <= last_v;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data     = out_data_r;
  assign out_where    = out_where_r;
  assign out_found    = out_found_r;
  assign out_size_now = out_size_r;
  assign out_last     = out_last_r;

endmodule

FILE: rtl/oul_cell.sv
// One list slot: holds a value, compares it with the search key and
// loads from the key or from a neighbor. Depends on oul_pkg.
module oul_cell import oul_pkg::*; #(
  parameter int IDX         = 0,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [CTL_W-1:0]       fill,
  input  logic [VALUE_WIDTH-1:0] left_data,
  input  logic [VALUE_WIDTH-1:0] right_data,
  output logic [VALUE_WIDTH-1:0] data,
  output logic                   hit
);

  localparam logic [CTL_W-1:0] MY_IDX = CTL_W'(IDX);

  logic [VALUE_WIDTH-1:0] data_r;
  logic                   in_span;

  assign in_span = (MY_IDX >= ctl.lo) && (MY_IDX <= ctl.hi);

  always_ff @(posedge clk) begin
    priority if (ctl.ld && (MY_IDX == ctl.ld_idx)) begin
      data_r <= key;
    end else if (ctl.shl && in_span) begin
      data_r <= left_data;
    end else if (ctl.shr && in_span) begin
      data_r <= right_data;
    end else begin
      data_r <= data_r;
    end
  end

  assign data = data_r;
  assign hit  = (data_r == key) && (MY_IDX < fill);

endmodule

FILE: tb/ordered_unique_value_list_unit_tb.sv
// Self-checking bench for ordered_unique_value_list_unit: directed and random list operations,
// each predicted by a local list model and checked per result transfer.
// Depends on oul_pkg and the unit's RTL.
module ordered_unique_value_list_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oul_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int NOT_STORED = -1;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  data;
    logic [WHERE_W-1:0] where;
    logic               found;
    logic [SIZE_W-1:0]  size_now;
    logic               last;
  } list_answer_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [KIND_W-1:0]        in_kind;
  logic signed [DATA_W-1:0] in_value;
  logic [POS_W-1:0]         in_position;
  logic [POS_W-1:0]         in_target;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_data;
  logic [WHERE_W-1:0]       out_where;
  logic                     out_found;
  logic [SIZE_W-1:0]        out_size_now;
  logic                     out_last;

  logic signed [DATA_W-1:0] stored[LIST_DEPTH];
  int                       fill = 0;
  list_answer_t             answers_due[$];
  int                       mismatches = 0;
  bit                       tx_steady = 1'b0;
  bit                       rx_steady = 1'b0;
  int                       rx_stall = 0;

  ordered_unique_value_list_unit #(
    .DEPTH(LIST_DEPTH),
    .VALUE_WIDTH(DATA_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_value(in_value),
    .in_position(in_position),
    .in_target(in_target),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_data(out_data),
    .out_where(out_where),
    .out_found(out_found),
    .out_size_now(out_size_now),
    .out_last(out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int locate_value(input logic signed [DATA_W-1:0] v);
    for (int i = 0; i < fill; i++) begin
      if (stored[i] == v) return i;
    end
    return NOT_STORED;
  endfunction

  function automatic void expect_answer(input stat_t st, input logic [DATA_W-1:0] data,
                                        input int where, input logic found, input logic last);
    list_answer_t a;
    a.status   = st;
    a.data     = data;
    a.where    = where[WHERE_W-1:0];
    a.found    = found;
    a.size_now = fill[SIZE_W-1:0];
    a.last     = last;
    answers_due.push_back(a);
  endfunction

  function automatic stat_t place_value(input logic signed [DATA_W-1:0] v, input int at);
    if (fill >= LIST_DEPTH) return STAT_FULL;
    for (int i = fill; i > at; i--) stored[i] = stored[i-1];
    stored[at] = v;
    fill++;
    return STAT_OK;
  endfunction

  function automatic void apply_list_op(input logic [KIND_W-1:0] kind,
                                        input logic signed [DATA_W-1:0] v,
                                        input logic [POS_W-1:0] position,
                                        input logic [POS_W-1:0] target);
    int                       at;
    int                       pos;
    int                       tgt;
    int                       dst;
    int                       stop;
    bit                       answered;
    stat_t                    st;
    logic signed [DATA_W-1:0] held;
    at = locate_value(v);
    pos = int'(position);
    tgt = int'(target);
    answered = 1'b0;
    st = STAT_OK;
    case (kind)
      KIND_ADD, KIND_ADD_ABSENT: begin
        if (at != NOT_STORED) st = (kind == KIND_ADD) ? STAT_DUP : STAT_OK;
        else st = place_value(v, fill);
      end
      KIND_INSERT: begin
        if (at != NOT_STORED) st = STAT_DUP;
        else if (pos > fill) st = STAT_BADIDX;
        else st = place_value(v, pos);
      end
      KIND_MOVE: begin
        if (at == NOT_STORED) begin
          st = STAT_ABSENT;
        end else if (tgt > fill) begin
          st = STAT_BADIDX;
        end else begin
          dst = (tgt == fill) ? fill - 1 : tgt;
          held = stored[at];
          if (dst < at) begin
            for (int i = at; i > dst; i--) stored[i] = stored[i-1];
          end else begin
            for (int i = at; i < dst; i++) stored[i] = stored[i+1];
          end
          stored[dst] = held;
        end
      end
      KIND_REMOVE, KIND_REMOVE_PRES: begin
        if (at != NOT_STORED) begin
          for (int i = at + 1; i < fill; i++) stored[i-1] = stored[i];
          fill--;
        end else begin
          st = (kind == KIND_REMOVE) ? STAT_ABSENT : STAT_OK;
        end
      end
      KIND_CLEAR: fill = 0;
      KIND_FIND: begin
        if (at != NOT_STORED) expect_answer(STAT_OK, '0, at, 1'b1, 1'b1);
        else expect_answer(STAT_ABSENT, '0, 0, 1'b0, 1'b1);
        answered = 1'b1;
      end
      KIND_READ_AT: begin
        if (pos < fill) expect_answer(STAT_OK, stored[pos], 0, 1'b0, 1'b1);
        else expect_answer(STAT_BADIDX, '0, 0, 1'b0, 1'b1);
        answered = 1'b1;
      end
      KIND_READ_RANGE: begin
        if (tgt < pos) begin
          expect_answer(STAT_BADIDX, '0, 0, 1'b0, 1'b1);
        end else if (pos >= fill) begin
          expect_answer(STAT_EMPTY, '0, 0, 1'b0, 1'b1);
        end else begin
          stop = (tgt < fill) ? tgt : fill - 1;
          for (int i = pos; i <= stop; i++) expect_answer(STAT_OK, stored[i], 0, 1'b0, i == stop);
        end
        answered = 1'b1;
      end
      default: st = STAT_OK;
    endcase
    if (!answered) expect_answer(st, '0, 0, 1'b0, 1'b1);
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] v,
                           input logic [POS_W-1:0] position, input logic [POS_W-1:0] target);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_value    <= v;
    in_position <= position;
    in_target   <= target;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_list_op(kind, v, position, target);
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 && fill > 0) return stored[$urandom_range(0, fill - 1)];
    if (r < 8) return int'($urandom_range(0, 15)) - 8;
    if (r == 8) return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_index();
    if ($urandom_range(0, 9) < 8) return POS_W'($urandom_range(0, fill + 1));
    return POS_W'($urandom_range(0, 63));
  endfunction

  task automatic check_answer();
    list_answer_t want;
    if (answers_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result transfer: status %0d data %0d", out_status, out_data);
    end else begin
      want = answers_due.pop_front();
      if (out_status !== want.status || out_data !== want.data || out_where !== want.where ||
          out_found !== want.found || out_size_now !== want.size_now ||
          out_last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected st %0d data %h where %0d found %b size %0d last %b",
                   $realtime, want.status, want.data, want.where, want.found, want.size_now,
                   want.last);
          $display("  got st %0d data %h where %0d found %b size %0d last %b",
                   out_status, out_data, out_where, out_found, out_size_now, out_last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_answer();
        if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
        rx_stall = rx_steady ? 0 : $urandom_range(0, 5);
      end
      if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_append();
    send_item(KIND_ADD, 32'sh8000_0000, 0, 0);
    send_item(KIND_ADD, 32'sh7fff_ffff, 63, 63);
    send_item(KIND_ADD, 0, 0, 0);
    send_item(KIND_ADD, 32'sh7fff_ffff, 0, 0);
    send_item(KIND_ADD_ABSENT, 0, 0, 0);
    send_item(KIND_ADD_ABSENT, -1, 0, 0);
  endtask

  task automatic test_insert();
    send_item(KIND_INSERT, 5, 0, 0);
    send_item(KIND_INSERT, 6, POS_W'(fill), 0);
    send_item(KIND_INSERT, 7, 2, 0);
    send_item(KIND_INSERT, 32'sh8000_0000, 1, 0);
    send_item(KIND_INSERT, 9, 63, 0);
  endtask

  task automatic test_move();
    send_item(KIND_MOVE, 6, 0, 0);
    send_item(KIND_MOVE, 5, 0, POS_W'(fill));
    send_item(KIND_MOVE, 100, 0, 1);
    send_item(KIND_MOVE, 7, 0, POS_W'(fill + 1));
    send_item(KIND_MOVE, 32'sh7fff_ffff, 0, 3);
  endtask

  task automatic test_remove_find();
    send_item(KIND_FIND, -1, 0, 0);
    send_item(KIND_FIND, 100, 0, 0);
    send_item(KIND_REMOVE, 100, 0, 0);
    send_item(KIND_REMOVE_PRES, 100, 0, 0);
    send_item(KIND_REMOVE, 32'sh8000_0000, 0, 0);
    send_item(KIND_REMOVE_PRES, 7, 0, 0);
  endtask

  task automatic test_reads();
    send_item(KIND_READ_AT, 0, 0, 0);
    send_item(KIND_READ_AT, 0, 63, 0);
    send_item(KIND_READ_RANGE, 0, 3, 1);
    send_item(KIND_READ_RANGE, 0, 40, 63);
    send_item(KIND_READ_RANGE, 0, 1, 63);
    send_item(4'd10, 32'sh5555_5555, 21, 42);
    send_item(4'd15, 32'shaaaa_aaaa, 42, 21);
    send_item(KIND_CLEAR, 0, 0, 0);
  endtask

  task automatic test_full_list();
    logic signed [DATA_W-1:0] v;
    tx_steady = 1'b1;
    send_item(KIND_CLEAR, 0, 0, 0);
    for (int i = 0; i < LIST_DEPTH; i++) begin
      do v = $urandom; while (locate_value(v) != NOT_STORED);
      send_item(KIND_ADD, v, 0, 0);
    end
    tx_steady = 1'b0;
    do v = $urandom; while (locate_value(v) != NOT_STORED);
    send_item(KIND_ADD, v, 0, 0);
    send_item(KIND_INSERT, v, 4, 0);
    send_item(KIND_INSERT, stored[3], 4, 0);
    send_item(KIND_INSERT, v, 33, 0);
    send_item(KIND_READ_RANGE, 0, 0, 63);
    drain_answers();
    send_item(KIND_FIND, stored[LIST_DEPTH-1], 0, 0);
    send_item(KIND_MOVE, stored[0], 0, POS_W'(LIST_DEPTH));
    send_item(KIND_READ_AT, 0, POS_W'(LIST_DEPTH - 1), 0);
    send_item(KIND_REMOVE, stored[10], 0, 0);
    send_item(KIND_ADD_ABSENT, v, 0, 0);
  endtask

  task automatic test_random_mix();
    int                r;
    logic [POS_W-1:0]  position;
    for (int n = 0; n < 36; n++) begin
      if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
      r = $urandom_range(0, 99);
      position = pick_index();
      if (r < 25)
        send_item(r < 17 ? KIND_ADD : KIND_ADD_ABSENT, pick_value(),
                  POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)));
      else if (r < 37)
        send_item(KIND_INSERT, pick_value(), position, POS_W'($urandom_range(0, 63)));
      else if (r < 49)
        send_item(KIND_MOVE, pick_value(), POS_W'($urandom_range(0, 63)), pick_index());
      else if (r < 67)
        send_item(r < 58 ? KIND_REMOVE : KIND_REMOVE_PRES, pick_value(), 0, 0);
      else if (r < 77)
        send_item(KIND_FIND, pick_value(), POS_W'($urandom_range(0, 63)), 0);
      else if (r < 85)
        send_item(KIND_READ_AT, $urandom, position, POS_W'($urandom_range(0, 63)));
      else if (r < 95)
        send_item(KIND_READ_RANGE, $urandom, position,
                  $urandom_range(0, 3) == 0 ? POS_W'($urandom_range(0, 63)) :
                  POS_W'(position + $urandom_range(0, 6)));
      else if (r < 97)
        send_item(KIND_CLEAR, $urandom, 0, 0);
      else
        send_item(KIND_W'($urandom_range(10, 15)), $urandom, POS_W'($urandom_range(0, 63)),
                  POS_W'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = '0;
    in_value    = '0;
    in_position = '0;
    in_target   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_append();
    test_insert();
    test_move();
    test_remove_find();
    test_reads();
    test_full_list();
    test_random_mix();
    drain_answers();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
